[sv/sha1h_pkg.sv]
// Shared types, constants and round functions for the SHA-1 message hasher.
package sha1h_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [6:0] LAST_RND  = 7'd79;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [2:0] LAST_WORD = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_message;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } t_state;

    function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        priority if (rnd < 7'd20) f = (b & c) | (~b & d);
        else if (rnd < 7'd40)     f = b ^ c ^ d;
        else if (rnd < 7'd60)     f = (b & c) | (b & d) | (c & d);
        else                      f = b ^ c ^ d;
        return f;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        logic [31:0] k;
        priority if (rnd < 7'd20) k = K0;
        else if (rnd < 7'd40)     k = K1;
        else if (rnd < 7'd60)     k = K2;
        else                      k = K3;
        return k;
    endfunction

endpackage

[sv/sha1h_front.sv]
// Input side: takes transactions and queues only those that carry work.
module sha1h_front import sha1h_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_end_message,
    input  t_qstat     i_qs,
    output logic       o_push,
    output t_item      o_item
);

    logic w_accept;

    assign o_stall  = i_qs.full;
    assign w_accept = i_valid && !i_qs.full;
    // an item with no byte and no end has no effect: drop it here
    assign o_push   = w_accept && (i_has_byte || i_end_message);
    assign o_item   = '{data_byte: i_data_byte, has_byte: i_has_byte,
                        end_message: i_end_message};

    property p_drop_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_has_byte && !i_end_message) |-> !o_push;
    endproperty
    a_drop_idle: assert property (p_drop_idle) else $error("empty item queued");

    property p_no_push_full;
        @(posedge i_clk) disable iff (!i_rst_n) i_qs.full |-> !o_push;
    endproperty
    a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

    property p_push_accepted;
        @(posedge i_clk) disable iff (!i_rst_n) o_push |-> (i_valid && !o_stall);
    endproperty
    a_push_accepted: assert property (p_push_accepted) else $error("push without accept");

endmodule

[sv/sha1h_queue.sv]
// Short item queue between the front and the hashing engine.
module sha1h_queue import sha1h_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_qs
);

    t_item            r_mem [QDepth];
    logic [QPtrW-1:0] r_wr;
    logic [QPtrW-1:0] r_rd;
    logic [QPtrW:0]   r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_qs.full  = (r_cnt == (QPtrW+1)'(QDepth));
    assign o_qs.empty = (r_cnt == '0);
    assign o_item     = r_mem[r_rd];
    assign w_push     = i_push && !o_qs.full;
    assign w_pop      = i_pop && !o_qs.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPtrW+1)'(w_push) - (QPtrW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    property p_cnt_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= (QPtrW+1)'(QDepth);
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("queue count overflow");

    property p_ptr_gap;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != (QPtrW+1)'(QDepth)) |-> ((r_wr - r_rd) == r_cnt[QPtrW-1:0]);
    endproperty
    a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers disagree with count");

    property p_pop_nonempty;
        @(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_qs.empty;
    endproperty
    a_pop_nonempty: assert property (p_pop_nonempty) else $error("pop from empty queue");

endmodule

[sv/sha1h_back.sv]
// Hashing engine: block buffer, padding, 80-round compression, digest output.
module sha1h_back import sha1h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  t_qstat      i_qs,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state, n_state;
    logic [31:0] r_w [16];     // block buffer, then rolling schedule
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_rnd;
    logic [5:0]  r_cnt;
    logic [63:0] r_bits;
    logic        r_padding, r_padded, r_wrap, r_final;
    logic [2:0]  r_oidx;
    logic        r_ovalid;
    logic [31:0] r_oword;
    logic [2:0]  r_oind;
    logic        r_olast;

    logic        w_shift, w_start, w_ld, w_len;
    logic [7:0]  w_byte;
    logic [5:0]  w_lsh;
    logic [31:0] w_new, w_t;

    assign o_pop         = (r_state == ST_IDLE) && !i_qs.empty;
    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oind;
    assign o_last_word   = r_olast;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_qs.empty) begin
                    if (i_item.has_byte && r_cnt == LAST_POS) n_state = ST_COMP;
                    else if (i_item.end_message)              n_state = ST_PAD;
                end
            end
            ST_PAD:  if (r_cnt == LAST_POS) n_state = ST_COMP;
            ST_COMP: if (r_rnd == LAST_RND) n_state = ST_ADD;
            ST_ADD: begin
                if (r_final)        n_state = ST_OUT;
                else if (r_padding) n_state = ST_PAD;
                else                n_state = ST_IDLE;
            end
            ST_OUT:  if (w_ld && r_oidx == LAST_WORD) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        // length bytes go at 56..63 of the final block, MSB first
        w_len   = (r_state == ST_PAD) && r_padded && !r_wrap && (r_cnt >= LEN_POS);
        w_lsh   = {~r_cnt[2:0], 3'b000};
        w_shift = (o_pop && i_item.has_byte) || (r_state == ST_PAD);
        w_start = w_shift && (r_cnt == LAST_POS);
        w_ld    = (r_state == ST_OUT) && (!r_ovalid || !i_stall);
        if (r_state != ST_PAD) w_byte = i_item.data_byte;
        else if (!r_padded)    w_byte = PAD_BYTE;
        else if (w_len)        w_byte = r_bits[w_lsh +: 8];
        else                   w_byte = '0;
        w_new = (r_rnd < 7'd16) ? r_w[0]
              : {(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]) << 1}
                | 32'((r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]));
        w_t   = {r_a[26:0], r_a[31:27]} + sha1_f(r_rnd, r_b, r_c, r_d) + r_e
              + sha1_k(r_rnd) + w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_bits    <= '0;
            r_h[0]    <= IV0;
            r_h[1]    <= IV1;
            r_h[2]    <= IV2;
            r_h[3]    <= IV3;
            r_h[4]    <= IV4;
            r_padding <= 1'b0;
            r_padded  <= 1'b0;
            r_wrap    <= 1'b0;
            r_final   <= 1'b0;
            r_oidx    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_shift) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_pop && i_item.has_byte) begin
                r_bits <= r_bits + 64'd8;
            end
            if (o_pop && i_item.end_message) begin
                r_padding <= 1'b1;
                r_padded  <= 1'b0;
            end
            if (r_state == ST_PAD) begin
                r_padded <= 1'b1;
                if (r_cnt == LAST_POS) r_wrap <= 1'b0;
                else if (!r_padded)    r_wrap <= (r_cnt >= LEN_POS);
                if (w_len && r_cnt == LAST_POS) r_final <= 1'b1;
            end
            if (r_state == ST_ADD) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (w_ld) begin
                r_ovalid <= 1'b1;
                if (r_oidx == LAST_WORD) begin
                    r_oidx    <= '0;
                    r_h[0]    <= IV0;
                    r_h[1]    <= IV1;
                    r_h[2]    <= IV2;
                    r_h[3]    <= IV3;
                    r_h[4]    <= IV4;
                    r_bits    <= '0;
                    r_padding <= 1'b0;
                    r_final   <= 1'b0;
                end else begin
                    r_oidx <= r_oidx + 1'b1;
                end
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], w_byte};
        end else if (r_state == ST_COMP) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
        if (w_start) begin
            r_a   <= r_h[0];
            r_b   <= r_h[1];
            r_c   <= r_h[2];
            r_d   <= r_h[3];
            r_e   <= r_h[4];
            r_rnd <= '0;
        end else if (r_state == ST_COMP) begin
            r_a   <= w_t;
            r_b   <= r_a;
            r_c   <= {r_b[1:0], r_b[31:2]};
            r_d   <= r_c;
            r_e   <= r_d;
            r_rnd <= r_rnd + 1'b1;
        end
        if (w_ld) begin
            r_oword <= r_h[r_oidx];
            r_oind  <= r_oidx;
            r_olast <= (r_oidx == LAST_WORD);
        end
    end

    property p_rose_from_out;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_ovalid) |-> $past(r_state == ST_OUT);
    endproperty
    a_rose_from_out: assert property (p_rose_from_out) else $error("digest word outside output");

    property p_comp_aligned;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP) |-> (r_cnt == '0 && r_rnd <= LAST_RND);
    endproperty
    a_comp_aligned: assert property (p_comp_aligned) else $error("compression misaligned");

    property p_len_final;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_final && !r_wrap);
    endproperty
    a_len_final: assert property (p_len_final) else $error("output before final block");

    property p_idx_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_oidx <= LAST_WORD;
    endproperty
    a_idx_range: assert property (p_idx_range) else $error("digest index out of range");

endmodule

[sv/sha1_message_hasher.sv]
// Streaming SHA-1 hasher: takes message bytes, emits the five-word digest.
// Message bytes go via a four-deep queue into the block buffer, one per cycle in the idle state.
// A full 64-byte block then holds the input through the 80 rounds of the round unit and the add.
// End of message: pad bytes go in one per cycle up to the block end, 1 or 2 compressions
// follow, then the five digest words leave one per cycle from the output register unless stalled.
// Synchronous active-low reset loads the initial hash value and empties queue and output.
module sha1_message_hasher import sha1h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_qstat w_qs;
    t_item  w_in_item;
    t_item  w_head;
    logic   w_push;
    logic   w_pop;

    sha1h_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_end_message (i_end_message),
        .i_qs          (w_qs),
        .o_push        (w_push),
        .o_item        (w_in_item)
    );

    sha1h_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_qs    (w_qs)
    );

    sha1h_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_head),
        .i_qs          (w_qs),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

[tb/sv/sha1_digest_checker.sv]
// Digest checker: watches both channels, predicts SHA-1 digests and compares.
module sha1_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_message,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    t_digest_word expected_words[$];
    logic [31:0]  hash_state[5];
    logic [7:0]   msg_block[64];
    int           block_fill;
    logic [63:0]  bit_length;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart_hash();
        hash_state[0] = sha1h_pkg::IV0;
        hash_state[1] = sha1h_pkg::IV1;
        hash_state[2] = sha1h_pkg::IV2;
        hash_state[3] = sha1h_pkg::IV3;
        hash_state[4] = sha1h_pkg::IV4;
        foreach (msg_block[i]) msg_block[i] = 8'h00;
        block_fill = 0;
        bit_length = '0;
    endtask

    task automatic compress();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        for (int j = 16; j < 80; j++)
            w[j] = rotl(w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16], 1);
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
        d = hash_state[3]; e = hash_state[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (r < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
        hash_state[3] += d; hash_state[4] += e;
    endtask

    task automatic absorb_item(input logic [7:0] data, input logic has, input logic last);
        int pos;
        t_digest_word dw;
        if (has) begin
            msg_block[block_fill] = data;
            bit_length += 64'd8;
            block_fill++;
            if (block_fill == 64) begin
                compress();
                block_fill = 0;
            end
        end
        if (last) begin
            pos = block_fill;
            msg_block[pos] = sha1h_pkg::PAD_BYTE;
            pos++;
            if (pos > 56) begin
                for (int i = pos; i < 64; i++) msg_block[i] = 8'h00;
                compress();
                pos = 0;
            end
            for (int i = pos; i < 56; i++) msg_block[i] = 8'h00;
            for (int i = 0; i < 8; i++) msg_block[56+i] = bit_length[63-8*i -: 8];
            compress();
            for (int i = 0; i < 5; i++) begin
                dw.word = hash_state[i];
                dw.index = 3'(i);
                dw.last = (i == 4);
                expected_words.push_back(dw);
            end
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        restart_hash();
    end

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_digest_word dw;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in)
                absorb_item(i_data_byte, i_has_byte, i_end_message);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected digest word", i_digest_word, 32'h0);
                end else begin
                    dw = expected_words.pop_front();
                    if (i_digest_word !== dw.word)
                        report_mismatch("digest_word", i_digest_word, dw.word);
                    if (i_word_index !== dw.index)
                        report_mismatch("word_index", 32'(i_word_index), 32'(dw.index));
                    if (i_last_word !== dw.last)
                        report_mismatch("last_word", 32'(i_last_word), 32'(dw.last));
                end
            end
        end
    end
endmodule

[tb/sv/tb_top.sv]
// Testbench top: drives byte streams into the SHA-1 hasher and gives the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_end_message = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_last_word;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    int          fail_count, words_due;
    bit          calm_phase;
    bit          hold_off;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sha1_message_hasher u_top (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data_byte, .i_has_byte,
        .i_end_message, .o_valid, .i_stall, .o_digest_word, .o_word_index, .o_last_word
    );

    sha1_digest_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_data_byte, .i_has_byte,
        .i_end_message, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_digest_word(o_digest_word), .i_word_index(o_word_index),
        .i_last_word(o_last_word), .o_errors(fail_count), .o_pending(words_due)
    );

    // one transaction; random idle cycles before it unless in the calm phase
    task automatic send_byte(input logic [7:0] data, input logic has, input logic last);
        while (!calm_phase && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= data;
        i_has_byte <= has;
        i_end_message <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit last_carries);
        for (int i = 0; i < len - (last_carries ? 1 : 0); i++) begin
            send_byte(8'($urandom), 1'b1, 1'b0);
            if ($urandom_range(15) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
        end
        send_byte(8'($urandom), last_carries, 1'b1);
    endtask

    // receiver: random stalls, a calm stretch, and one long hold-off
    initial begin
        @(negedge i_clk);
        forever begin
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            i_stall <= (!calm_phase && $urandom_range(99) < 31);
            @(negedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int len;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: empty, byte extremes, no-op item, pad boundaries
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b1, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(64, 1'b1);
        // long hold-off while bytes keep coming
        hold_off = 1'b1;
        send_message(10, 1'b0);
        calm_phase = 1'b1;
        send_message(30, 1'b1);
        calm_phase = 1'b0;
        for (int m = 0; m < 6; m++) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(100) : $urandom_range(12);
            send_message(len, len > 0 && $urandom_range(1));
        end
        i_valid <= 1'b0;
        while (words_due != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
